// ===== hdl/rfuv_pkg.sv =====
package rfuv_pkg;

  localparam int UV_FRAC_BITS_DEF = 16;

  localparam int UV_W     = 17;
  localparam int NRM_W    = 16;
  localparam int DST_W    = 16;
  localparam int VP_W     = 14;
  localparam int MO_W     = 16;
  localparam int PIX_W    = 16;
  localparam int PROD_W   = 31;
  localparam int RND_BITS = 14;
  localparam int LSQ_W    = 33;
  localparam int LEN_W    = 17;
  localparam int SCL_W    = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int S_DATA_W   = 88;
  localparam int M_DATA_W   = 40;

  localparam logic [CFG_IDX_W-1:0] REG_VP_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VP_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OFFSET = 2'd2;

  localparam logic [VP_W-1:0] VP_WIDTH_RST   = 14'd1920;
  localparam logic [VP_W-1:0] VP_HEIGHT_RST  = 14'd1080;
  localparam logic [MO_W-1:0] MAX_OFFSET_RST = 16'd4096;

  typedef struct packed {
    logic [UV_W-1:0] u;
    logic [UV_W-1:0] v;
    logic            sx;
    logic            sz;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] pz;
    logic             clamp;
  } geo_t;

  typedef struct packed {
    logic [VP_W-1:0] width;
    logic [VP_W-1:0] height;
    logic [MO_W-1:0] max_offset;
  } cfg_t;

endpackage

// ===== hdl/rfuv_front.sv =====
module rfuv_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic        [rfuv_pkg::UV_W-1:0]  src_u,
  input  logic        [rfuv_pkg::UV_W-1:0]  src_v,
  input  logic signed [rfuv_pkg::NRM_W-1:0] normal_x,
  input  logic signed [rfuv_pkg::NRM_W-1:0] normal_z,
  input  logic signed [rfuv_pkg::DST_W-1:0] optical_distance,
  input  rfuv_pkg::cfg_t                    cfg,
  output logic                              out_valid,
  output rfuv_pkg::geo_t                    geo,
  output logic        [rfuv_pkg::LSQ_W-1:0] lensq
);
  import rfuv_pkg::*;

  logic [NRM_W-1:0]   mag_x, mag_z;
  logic [DST_W-2:0]   dm;
  logic               v1, v2, v3;
  side_t              side1, side2, side3;
  logic [PROD_W-1:0]  prod_x, prod_z;
  logic [PROD_W-1:0]  rnd_x, rnd_z;
  logic [PIX_W-1:0]   px2, pz2, px3, pz3;
  logic [2*PIX_W-1:0] sq_x, sq_z, msq;
  logic [LSQ_W-1:0]   lensq_next;

  always_comb begin
    mag_x = normal_x[NRM_W-1] ? NRM_W'(-normal_x) : NRM_W'(normal_x);
    mag_z = normal_z[NRM_W-1] ? NRM_W'(-normal_z) : NRM_W'(normal_z);
    dm = optical_distance[DST_W-1] ? '0 : optical_distance[DST_W-2:0];
    rnd_x = prod_x + PROD_W'(1 << (RND_BITS - 1));
    rnd_z = prod_z + PROD_W'(1 << (RND_BITS - 1));
    lensq_next = LSQ_W'(sq_x) + LSQ_W'(sq_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1 <= '{u: src_u, v: src_v, sx: normal_x[NRM_W-1], sz: normal_z[NRM_W-1]};
      prod_x <= PROD_W'(mag_x) * PROD_W'(dm);
      prod_z <= PROD_W'(mag_z) * PROD_W'(dm);
      side2 <= side1;
      px2 <= rnd_x[RND_BITS +: PIX_W];
      pz2 <= rnd_z[RND_BITS +: PIX_W];
      side3 <= side2;
      px3 <= px2;
      pz3 <= pz2;
      sq_x <= (2*PIX_W)'(px2) * (2*PIX_W)'(px2);
      sq_z <= (2*PIX_W)'(pz2) * (2*PIX_W)'(pz2);
      msq <= (2*PIX_W)'(cfg.max_offset) * (2*PIX_W)'(cfg.max_offset);
      lensq <= lensq_next;
      geo <= '{side: side3, px: px3, pz: pz3, clamp: (lensq_next > LSQ_W'(msq))};
    end
  end

`ifndef SYNTHESIS
  a_clamp_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && geo.clamp |-> lensq != '0)
    else $error("clamp flagged on a zero length offset");
`endif

endmodule

// ===== hdl/rfuv_sqrt.sv =====
module rfuv_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  rfuv_pkg::geo_t                    in_geo,
  input  logic        [rfuv_pkg::LSQ_W-1:0] lensq,
  output logic                              out_valid,
  output rfuv_pkg::geo_t                    out_geo,
  output logic        [rfuv_pkg::LEN_W-1:0] root
);
  import rfuv_pkg::*;

  localparam int STG = LEN_W;
  localparam int RW  = LEN_W + 1;
  localparam int XW  = 2 * LEN_W;

  logic             vld [STG];
  geo_t             g   [STG];
  logic [RW-1:0]    rem [STG];
  logic [LEN_W-1:0] rt  [STG];
  logic [XW-1:0]    x   [STG];

  for (genvar s = 0; s < STG; s++) begin : g_stage
    logic             v_i;
    geo_t             g_i;
    logic [RW-1:0]    rem_i;
    logic [LEN_W-1:0] rt_i;
    logic [XW-1:0]    x_i;
    logic [RW+1:0]    rem_s;
    logic [RW:0]      trial;
    logic [RW-1:0]    rem_n;
    logic [LEN_W-1:0] rt_n;

    if (s == 0) begin : g_first
      assign v_i = in_valid;
      assign g_i = in_geo;
      assign rem_i = '0;
      assign rt_i = '0;
      assign x_i = XW'(lensq);
    end else begin : g_next
      assign v_i = vld[s-1];
      assign g_i = g[s-1];
      assign rem_i = rem[s-1];
      assign rt_i = rt[s-1];
      assign x_i = x[s-1];
    end

    always_comb begin
      rem_s = {rem_i, x_i[XW-1 -: 2]};
      trial = {rt_i, 2'b01};
      if (rem_s >= (RW+2)'(trial)) begin
        rem_n = RW'(rem_s - (RW+2)'(trial));
        rt_n = {rt_i[LEN_W-2:0], 1'b1};
      end else begin
        rem_n = rem_s[RW-1:0];
        rt_n = {rt_i[LEN_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        g[s] <= g_i;
        rem[s] <= rem_n;
        rt[s] <= rt_n;
        x[s] <= {x_i[XW-3:0], 2'b00};
      end
    end
  end

  assign out_valid = vld[STG-1];
  assign out_geo = g[STG-1];
  assign root = rt[STG-1];

`ifndef SYNTHESIS
  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    vld[STG-1] |-> rem[STG-1] <= {rt[STG-1], 1'b0})
    else $error("square root remainder out of range");
`endif

endmodule

// ===== hdl/rfuv_div.sv =====
module rfuv_div #(
  parameter int NW = 32,
  parameter int DW = 17,
  parameter int PW = 36
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num0,
  input  logic [NW-1:0] num1,
  input  logic [DW-1:0] den0,
  input  logic [DW-1:0] den1,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [NW-1:0] quo0,
  output logic [NW-1:0] quo1,
  output logic [PW-1:0] out_pay
);

  logic          vld [NW];
  logic [PW-1:0] pay [NW];
  logic [DW-1:0] rem [NW][2];
  logic [NW-1:0] nq  [NW][2];
  logic [DW-1:0] dv  [NW][2];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          v_i;
    logic [PW-1:0] p_i;
    logic [DW-1:0] rem_i [2];
    logic [NW-1:0] n_i   [2];
    logic [DW-1:0] d_i   [2];
    logic [DW:0]   rem_s [2];
    logic [DW-1:0] rem_n [2];
    logic [NW-1:0] n_n   [2];

    if (s == 0) begin : g_first
      assign v_i = in_valid;
      assign p_i = in_pay;
      assign rem_i[0] = '0;
      assign rem_i[1] = '0;
      assign n_i[0] = num0;
      assign n_i[1] = num1;
      assign d_i[0] = den0;
      assign d_i[1] = den1;
    end else begin : g_next
      assign v_i = vld[s-1];
      assign p_i = pay[s-1];
      assign rem_i[0] = rem[s-1][0];
      assign rem_i[1] = rem[s-1][1];
      assign n_i[0] = nq[s-1][0];
      assign n_i[1] = nq[s-1][1];
      assign d_i[0] = dv[s-1][0];
      assign d_i[1] = dv[s-1][1];
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        rem_s[l] = {rem_i[l], n_i[l][NW-1]};
        if (rem_s[l] >= {1'b0, d_i[l]}) begin
          rem_n[l] = DW'(rem_s[l] - {1'b0, d_i[l]});
          n_n[l] = {n_i[l][NW-2:0], 1'b1};
        end else begin
          rem_n[l] = rem_s[l][DW-1:0];
          n_n[l] = {n_i[l][NW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pay[s] <= p_i;
        for (int l = 0; l < 2; l++) begin
          rem[s][l] <= rem_n[l];
          nq[s][l] <= n_n[l];
          dv[s][l] <= d_i[l];
        end
      end
    end
  end

  assign out_valid = vld[NW-1];
  assign out_pay = pay[NW-1];
  assign quo0 = nq[NW-1][0];
  assign quo1 = nq[NW-1][1];

`ifndef SYNTHESIS
  a_rem0: assert property (@(posedge clk) disable iff (rst)
    vld[NW-1] && (dv[NW-1][0] != '0) |-> rem[NW-1][0] < dv[NW-1][0])
    else $error("lane 0 remainder not below divisor");
  a_rem1: assert property (@(posedge clk) disable iff (rst)
    vld[NW-1] && (dv[NW-1][1] != '0) |-> rem[NW-1][1] < dv[NW-1][1])
    else $error("lane 1 remainder not below divisor");
`endif

endmodule

// ===== hdl/rfuv_back.sv =====
module rfuv_back #(
  parameter int UV_FRAC_BITS = rfuv_pkg::UV_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [UV_FRAC_BITS+7:0]          q_u,
  input  logic [UV_FRAC_BITS+7:0]          q_v,
  input  rfuv_pkg::side_t                  side,
  input  rfuv_pkg::cfg_t                   cfg,
  output logic                             out_valid,
  output logic [rfuv_pkg::UV_W-1:0]        out_u,
  output logic [rfuv_pkg::UV_W-1:0]        out_v,
  output logic                             refracted
);
  import rfuv_pkg::*;

  localparam int F  = UV_FRAC_BITS;
  localparam int CW = F + 10;
  localparam int MW = F + 9;
  localparam int PW = MW + VP_W + 1;

  logic            v1, v2;
  logic [CW-1:0]   cu_next, cv_next, cu, cv;
  logic [UV_W-1:0] u1, v1c, u2, v2c, cu2, cv2;
  logic [PW-1:0]   pu, pv;
  logic            neg_u, neg_v;
  logic [VP_W:0]   tw_u, tw_v;
  logic [PW-1:0]   bnd_u, bnd_v, one;
  logic            ok_u, ok_v, refr;

  always_comb begin
    cu_next = CW'(side.u) + (side.sx ? -CW'(q_u) : CW'(q_u));
    cv_next = CW'(side.v) + (side.sz ? -CW'(q_v) : CW'(q_v));
    tw_u = {cfg.width, 1'b0};
    tw_v = {cfg.height, 1'b0};
    one = PW'(1) << F;
    bnd_u = PW'(tw_u - (VP_W+1)'(1)) << F;
    bnd_v = PW'(tw_v - (VP_W+1)'(1)) << F;
    ok_u = !neg_u && (pu >= one) && (pu <= bnd_u);
    ok_v = !neg_v && (pv >= one) && (pv <= bnd_v);
    refr = ok_u && ok_v && (cfg.width != '0) && (cfg.height != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cu <= cu_next;
      cv <= cv_next;
      u1 <= side.u;
      v1c <= side.v;
      pu <= PW'(cu[MW-1:0]) * PW'(tw_u);
      pv <= PW'(cv[MW-1:0]) * PW'(tw_v);
      neg_u <= cu[CW-1];
      neg_v <= cv[CW-1];
      cu2 <= cu[UV_W-1:0];
      cv2 <= cv[UV_W-1:0];
      u2 <= u1;
      v2c <= v1c;
      out_u <= refr ? cu2 : u2;
      out_v <= refr ? cv2 : v2c;
      refracted <= refr;
    end
  end

endmodule

// ===== hdl/refraction_uv_offset_clamp.sv =====
// Screen-space refraction coordinate: one pixel per clock while the output is not stalled. Each pixel's offset is
// normal times the non-negative optical distance, scaled down to max_offset when longer, divided
// by the viewport size and added to the source coordinate; out of the half-texel inset, or with a
// zero viewport dimension, the source comes back with refracted low. The square root has 17
// stages, and the two dividers resolve one bit per stage (32 stages for the length scaling,
// UV_FRAC_BITS + 8 for the viewport). A stalled output holds the whole pipeline.
// Configuration may be written only while no pixel is in flight.
module refraction_uv_offset_clamp #(
  parameter int UV_FRAC_BITS = rfuv_pkg::UV_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // src_u, src_v, normal_x, normal_z, optical_distance, zero pad
  input  logic [rfuv_pkg::S_DATA_W-1:0]        s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // out_u, out_v, zero pad
  output logic [rfuv_pkg::M_DATA_W-1:0]        m_tdata,
  // refracted
  output logic                                 m_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rfuv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rfuv_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rfuv_pkg::*;

  localparam int QW = UV_FRAC_BITS + 8;

  cfg_t                 cfg;
  logic                 en;
  logic                 fr_valid, sq_valid, sc_valid, d1_valid, d2_valid;
  geo_t                 fr_geo, sq_geo;
  logic [LSQ_W-1:0]     fr_lensq;
  logic [LEN_W-1:0]     sq_root;
  logic [SCL_W-1:0]     num_x, num_z, q1_x, q1_z;
  logic [LEN_W-1:0]     den_x, den_z;
  side_t                sc_side, d1_side, d2_side;
  logic [QW-1:0]        n2_x, n2_z, q2_x, q2_z;
  logic [UV_W-1:0]      out_u, out_v;
  logic                 refracted;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;
  assign cfg_ready = 1'b1;
  assign m_tdata = {(M_DATA_W - 2*UV_W)'(0), out_v, out_u};
  assign m_tuser = refracted;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width <= VP_WIDTH_RST;
      cfg.height <= VP_HEIGHT_RST;
      cfg.max_offset <= MAX_OFFSET_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VP_WIDTH:   cfg.width <= cfg_data[VP_W-1:0];
        REG_VP_HEIGHT:  cfg.height <= cfg_data[VP_W-1:0];
        REG_MAX_OFFSET: cfg.max_offset <= cfg_data[MO_W-1:0];
        default: ;
      endcase
    end
  end

  rfuv_front u_front (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(s_tvalid),
    .src_u(s_tdata[16:0]),
    .src_v(s_tdata[33:17]),
    .normal_x(s_tdata[49:34]),
    .normal_z(s_tdata[65:50]),
    .optical_distance(s_tdata[81:66]),
    .cfg(cfg),
    .out_valid(fr_valid),
    .geo(fr_geo),
    .lensq(fr_lensq)
  );

  rfuv_sqrt u_sqrt (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(fr_valid),
    .in_geo(fr_geo),
    .lensq(fr_lensq),
    .out_valid(sq_valid),
    .out_geo(sq_geo),
    .root(sq_root)
  );

  // length scaling operands, unit divisor when no clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      sc_valid <= 1'b0;
    end else if (en) begin
      sc_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_side <= sq_geo.side;
      if (sq_geo.clamp) begin
        num_x <= SCL_W'(sq_geo.px) * SCL_W'(cfg.max_offset);
        num_z <= SCL_W'(sq_geo.pz) * SCL_W'(cfg.max_offset);
        den_x <= sq_root;
        den_z <= sq_root;
      end else begin
        num_x <= SCL_W'(sq_geo.px);
        num_z <= SCL_W'(sq_geo.pz);
        den_x <= LEN_W'(1);
        den_z <= LEN_W'(1);
      end
    end
  end

  rfuv_div #(
    .NW(SCL_W),
    .DW(LEN_W),
    .PW($bits(side_t))
  ) u_div_len (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(sc_valid),
    .num0(num_x),
    .num1(num_z),
    .den0(den_x),
    .den1(den_z),
    .in_pay(sc_side),
    .out_valid(d1_valid),
    .quo0(q1_x),
    .quo1(q1_z),
    .out_pay(d1_side)
  );

  assign n2_x = QW'(q1_x[PIX_W-1:0]) << (UV_FRAC_BITS - 8);
  assign n2_z = QW'(q1_z[PIX_W-1:0]) << (UV_FRAC_BITS - 8);

  rfuv_div #(
    .NW(QW),
    .DW(VP_W),
    .PW($bits(side_t))
  ) u_div_vp (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(d1_valid),
    .num0(n2_x),
    .num1(n2_z),
    .den0(cfg.width),
    .den1(cfg.height),
    .in_pay(d1_side),
    .out_valid(d2_valid),
    .quo0(q2_x),
    .quo1(q2_z),
    .out_pay(d2_side)
  );

  rfuv_back #(
    .UV_FRAC_BITS(UV_FRAC_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(d2_valid),
    .q_u(q2_x),
    .q_v(q2_z),
    .side(d2_side),
    .cfg(cfg),
    .out_valid(m_tvalid),
    .out_u(out_u),
    .out_v(out_v),
    .refracted(refracted)
  );

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");
`endif

endmodule
